/* hw/rtl/imupp_pkg.sv */
`default_nettype none

package imupp_pkg;

  // Header bytes that open every packet.
  localparam logic [7:0] HDR_S = 8'h73;
  localparam logic [7:0] HDR_N = 8'h6E;
  localparam logic [7:0] HDR_P = 8'h70;

  // Sum of the three header bytes, the seed of the running checksum.
  localparam logic [15:0] HDR_SUM = 16'({8'd0, HDR_S} + {8'd0, HDR_N} + {8'd0, HDR_P});

  // Register addresses that carry values.
  localparam logic [7:0] ADDR_QUAT  = 8'h6D;
  localparam logic [7:0] ADDR_EULER = 8'h70;

  // Batch length field mask in the type byte.
  localparam logic [3:0] LEN_MASK = 4'hF;

  // Unpacking reads only the first seven words, so only these payload bytes are kept.
  localparam int STORE_BYTES = 14;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  // Number of value registers.
  localparam int NUM_VALUES = 10;

  // Parser phase codes.
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_S    = 3'd1;
  localparam logic [2:0] PH_SN   = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_ADDR = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CHKH = 3'd6;
  localparam logic [2:0] PH_CHKL = 3'd7;

  typedef logic [15:0] value_t;

endpackage

`default_nettype wire

/* hw/rtl/imu_packet_parser.sv */
`default_nettype none
// Each accepted byte word yields a registered result word. Throughput: one byte
// word per cycle while in_ready is high; the parse state and the output register
// are updated in the same clock edge, so the running checksum loop sets the pace.
// Reset (rst_n low, synchronous) returns the parser to header hunt, clears the
// value registers and the output valid; the kept payload bytes are not cleared.

module imu_packet_parser (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_packet_ok,
  output logic                    out_checksum_bad,
  output logic signed [15:0]      out_quat_a,
  output logic signed [15:0]      out_quat_b,
  output logic signed [15:0]      out_quat_c,
  output logic signed [15:0]      out_quat_d,
  output logic signed [15:0]      out_roll_angle,
  output logic signed [15:0]      out_pitch_angle,
  output logic signed [15:0]      out_yaw_angle,
  output logic signed [15:0]      out_roll_speed,
  output logic signed [15:0]      out_pitch_speed,
  output logic signed [15:0]      out_yaw_speed
);

  // Control state.
  logic [2:0]  phase_r, phase_nxt;
  logic        batch_r, batch_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;
  logic [15:0] sum_r, sum_nxt;

  // Output stage.
  logic        out_valid_r, out_valid_nxt;
  logic        ok_r, ok_nxt;
  logic        bad_r, bad_nxt;
  imupp_pkg::value_t vals_r   [imupp_pkg::NUM_VALUES];
  imupp_pkg::value_t vals_nxt [imupp_pkg::NUM_VALUES];

  // Kept payload bytes.
  logic [7:0]  store_r [imupp_pkg::STORE_BYTES];
  logic        store_we;

  logic        accept;
  logic [5:0]  count_inc;
  logic [7:0]  c;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign c        = in_rx_byte;
  assign count_inc = count_r + 6'd1;

  // A payload byte is kept only while its position is one that unpacking reads.
  assign store_we = accept && (phase_r == imupp_pkg::PH_DATA) &&
                    (count_r < 6'(imupp_pkg::STORE_BYTES));

  // Next-state logic for one byte word.
  always_comb begin
    phase_nxt     = phase_r;
    batch_nxt     = batch_r;
    plen_nxt      = plen_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    chk_hi_nxt    = chk_hi_r;
    sum_nxt       = sum_r;
    ok_nxt        = ok_r;
    bad_nxt       = bad_r;
    vals_nxt      = vals_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = 1'b0;
      bad_nxt       = 1'b0;
      case (phase_r)
        imupp_pkg::PH_HUNT: begin
          phase_nxt = (c == imupp_pkg::HDR_S) ? imupp_pkg::PH_S : imupp_pkg::PH_HUNT;
        end
        imupp_pkg::PH_S: begin
          phase_nxt = (c == imupp_pkg::HDR_N) ? imupp_pkg::PH_SN : imupp_pkg::PH_HUNT;
        end
        imupp_pkg::PH_SN: begin
          phase_nxt = (c == imupp_pkg::HDR_P) ? imupp_pkg::PH_TYPE : imupp_pkg::PH_HUNT;
        end
        imupp_pkg::PH_TYPE: begin
          batch_nxt = c[6];
          if (c[7]) begin
            plen_nxt = c[6] ? {c[5:2] & imupp_pkg::LEN_MASK, 2'b00} : 6'd4;
          end else begin
            plen_nxt = 6'd0;
          end
          sum_nxt   = imupp_pkg::HDR_SUM + {8'd0, c};
          phase_nxt = imupp_pkg::PH_ADDR;
        end
        imupp_pkg::PH_ADDR: begin
          addr_nxt  = c;
          count_nxt = 6'd0;
          sum_nxt   = sum_r + {8'd0, c};
          phase_nxt = (plen_r == 6'd0) ? imupp_pkg::PH_CHKH : imupp_pkg::PH_DATA;
        end
        imupp_pkg::PH_DATA: begin
          count_nxt = count_inc;
          sum_nxt   = sum_r + {8'd0, c};
          if (count_inc >= plen_r) begin
            phase_nxt = imupp_pkg::PH_CHKH;
          end
        end
        imupp_pkg::PH_CHKH: begin
          chk_hi_nxt = c;
          phase_nxt  = imupp_pkg::PH_CHKL;
        end
        default: begin
          phase_nxt = imupp_pkg::PH_HUNT;
          if ({chk_hi_r, c} == sum_r) begin
            ok_nxt = 1'b1;
            // Unpack big-endian words from their fixed payload positions.
            if (addr_r == imupp_pkg::ADDR_QUAT) begin
              vals_nxt[0] = {store_r[0], store_r[1]};
              vals_nxt[1] = {store_r[2], store_r[3]};
              if (batch_r) begin
                vals_nxt[2] = {store_r[4], store_r[5]};
                vals_nxt[3] = {store_r[6], store_r[7]};
              end
            end else if (addr_r == imupp_pkg::ADDR_EULER) begin
              vals_nxt[4] = {store_r[0], store_r[1]};
              vals_nxt[5] = {store_r[2], store_r[3]};
              if (batch_r) begin
                // The fourth word is skipped; rates follow it.
                vals_nxt[6] = {store_r[4], store_r[5]};
                vals_nxt[7] = {store_r[8], store_r[9]};
                vals_nxt[8] = {store_r[10], store_r[11]};
                vals_nxt[9] = {store_r[12], store_r[13]};
              end
            end
          end else begin
            bad_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= imupp_pkg::PH_HUNT;
      batch_r     <= 1'b0;
      plen_r      <= 6'd0;
      addr_r      <= 8'd0;
      count_r     <= 6'd0;
      chk_hi_r    <= 8'd0;
      sum_r       <= 16'd0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      bad_r       <= 1'b0;
      for (int i = 0; i < imupp_pkg::NUM_VALUES; i++) begin
        vals_r[i] <= '0;
      end
    end else begin
      phase_r     <= phase_nxt;
      batch_r     <= batch_nxt;
      plen_r      <= plen_nxt;
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
      chk_hi_r    <= chk_hi_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      bad_r       <= bad_nxt;
      vals_r      <= vals_nxt;
    end
  end

  // Payload byte store, no reset.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[imupp_pkg::STORE_AW-1:0]] <= c;
    end
  end

  // Result word ports.
  assign out_valid        = out_valid_r;
  assign out_packet_ok    = ok_r;
  assign out_checksum_bad = bad_r;
  assign out_quat_a       = vals_r[0];
  assign out_quat_b       = vals_r[1];
  assign out_quat_c       = vals_r[2];
  assign out_quat_d       = vals_r[3];
  assign out_roll_angle   = vals_r[4];
  assign out_pitch_angle  = vals_r[5];
  assign out_yaw_angle    = vals_r[6];
  assign out_roll_speed   = vals_r[7];
  assign out_pitch_speed  = vals_r[8];
  assign out_yaw_speed    = vals_r[9];

endmodule

`default_nettype wire
